// File: design/hrp_pkg.sv
// Shared types, codes and the hex digit helper function of the hex record parser.
package hrp_pkg;

  localparam int unsigned MAX_LEN = 16;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_BASE = 8'h04;

  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_EOF       = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_TYPE  = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] address;
    logic [3:0]  byte_index;
    logic [7:0]  data_byte;
    logic [7:0]  record_length;
    logic        last;
  } record_t;

  // Characters outside 0-9, A-F and a-f decode as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end
    return v;
  endfunction

endpackage

// File: design/hrp_ifs.sv
// Valid/ready channel interfaces for characters in and parsed records out.
interface hrp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface hrp_record_if;
  logic            valid;
  logic            ready;
  hrp_pkg::record_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/hex_record_parser.sv
// Character-serial hex record parser with a registered result stage.
//
//   Channel  Direction  Payload
//   chars    in         character (8 bits), one ASCII byte per transfer
//   records  out        status, address, byte_index, data_byte, record_length, last
//
// Each character is decoded in the cycle of its transfer.
// A result appears in the output register on the cycle after the character that caused it.
// The parser accepts a character in every cycle unless a result waits in the output
// register and the sink is not ready; then chars.ready is low.
// Reset (rst, synchronous, active high) returns the parser to expecting a colon.
module hex_record_parser (
  input  logic         clk,
  input  logic         rst,
  hrp_char_if.sink     chars,
  hrp_record_if.source records
);
  import hrp_pkg::*;

  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_HUNT  = 4'd1,
    PH_LEN   = 4'd2,
    PH_ADDR  = 4'd3,
    PH_TYPE  = 4'd4,
    PH_BASE  = 4'd5,
    PH_DATA  = 4'd6,
    PH_SKIP  = 4'd7,
    PH_LF    = 4'd8
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [7:0]  length_field, length_field_next;
  logic [15:0] offset_field, offset_field_next;
  logic [7:0]  type_field, type_field_next;
  logic [15:0] upper_base, upper_base_next;
  logic [7:0]  byte_accumulator, byte_accumulator_next;
  logic [7:0]  bytes_done, bytes_done_next;

  logic        out_valid;
  record_t     out_record;
  logic        emit;
  record_t     result;

  logic        accept;
  logic [7:0]  c;
  logic [3:0]  v;
  logic [2:0]  dc_inc;
  logic [7:0]  done_inc;
  logic        is_last;

  assign chars.ready     = !out_valid || records.ready;
  assign accept          = chars.valid && chars.ready;
  assign records.valid   = out_valid;
  assign records.payload = out_record;

  assign c        = chars.character;
  assign v        = hex_value(c);
  assign dc_inc   = 3'(digit_count + 3'd1);
  assign done_inc = 8'(bytes_done + 8'd1);
  assign is_last  = (done_inc == length_field);

  always_comb begin
    phase_next            = phase;
    digit_count_next      = digit_count;
    length_field_next     = length_field;
    offset_field_next     = offset_field;
    type_field_next       = type_field;
    upper_base_next       = upper_base;
    byte_accumulator_next = byte_accumulator;
    bytes_done_next       = bytes_done;
    emit                  = 1'b0;
    result                = '0;
    result.status         = ST_DATA;
    case (phase)
      PH_START, PH_LF: begin
        if (phase == PH_LF && c == CHAR_LF) begin
          phase_next = PH_START;
        end else if (c == CHAR_COLON) begin
          phase_next        = PH_LEN;
          digit_count_next  = 3'd0;
          length_field_next = 8'd0;
        end else begin
          phase_next    = PH_HUNT;
          emit          = 1'b1;
          result.status = ST_BAD_START;
        end
      end
      PH_HUNT: begin
        if (c == CHAR_COLON) begin
          phase_next        = PH_LEN;
          digit_count_next  = 3'd0;
          length_field_next = 8'd0;
        end
      end
      PH_LEN: begin
        length_field_next = {length_field[3:0], v};
        digit_count_next  = dc_inc;
        if (dc_inc >= 3'd2) begin
          if (length_field_next > 8'(MAX_LEN) || length_field_next[0]) begin
            phase_next           = PH_HUNT;
            emit                 = 1'b1;
            result.status        = ST_BAD_LEN;
            result.record_length = length_field_next;
          end else begin
            phase_next        = PH_ADDR;
            digit_count_next  = 3'd0;
            offset_field_next = 16'd0;
          end
        end
      end
      PH_ADDR: begin
        offset_field_next = {offset_field[11:0], v};
        digit_count_next  = dc_inc;
        if (dc_inc >= 3'd4) begin
          phase_next       = PH_TYPE;
          digit_count_next = 3'd0;
          type_field_next  = 8'd0;
        end
      end
      PH_TYPE: begin
        type_field_next  = {type_field[3:0], v};
        digit_count_next = dc_inc;
        if (dc_inc >= 3'd2) begin
          digit_count_next = 3'd0;
          if (type_field_next == REC_EOF) begin
            phase_next           = PH_HUNT;
            emit                 = 1'b1;
            result.status        = ST_EOF;
            result.record_length = length_field;
          end else if (type_field_next == REC_BASE) begin
            phase_next      = PH_BASE;
            upper_base_next = 16'd0;
          end else if (type_field_next == REC_DATA) begin
            bytes_done_next       = 8'd0;
            byte_accumulator_next = 8'd0;
            phase_next            = (length_field == 8'd0) ? PH_SKIP : PH_DATA;
          end else begin
            phase_next           = PH_HUNT;
            emit                 = 1'b1;
            result.status        = ST_BAD_TYPE;
            result.record_length = length_field;
          end
        end
      end
      PH_BASE: begin
        upper_base_next  = {upper_base[11:0], v};
        digit_count_next = dc_inc;
        if (dc_inc >= 3'd4) begin
          phase_next       = PH_SKIP;
          digit_count_next = 3'd0;
        end
      end
      PH_DATA: begin
        byte_accumulator_next = {byte_accumulator[3:0], v};
        digit_count_next      = dc_inc;
        if (dc_inc >= 3'd2) begin
          digit_count_next      = 3'd0;
          emit                  = 1'b1;
          result.status         = ST_DATA;
          result.address        = {upper_base, offset_field};
          result.byte_index     = bytes_done[3:0];
          result.data_byte      = byte_accumulator_next;
          result.record_length  = length_field;
          result.last           = is_last;
          bytes_done_next       = done_inc;
          byte_accumulator_next = 8'd0;
          if (is_last) begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        digit_count_next = dc_inc;
        if (dc_inc >= 3'd3) begin
          phase_next       = PH_LF;
          digit_count_next = 3'd0;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      digit_count      <= 3'd0;
      length_field     <= 8'd0;
      offset_field     <= 16'd0;
      type_field       <= 8'd0;
      upper_base       <= 16'd0;
      byte_accumulator <= 8'd0;
      bytes_done       <= 8'd0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        phase            <= phase_next;
        digit_count      <= digit_count_next;
        length_field     <= length_field_next;
        offset_field     <= offset_field_next;
        type_field       <= type_field_next;
        upper_base       <= upper_base_next;
        byte_accumulator <= byte_accumulator_next;
        bytes_done       <= bytes_done_next;
      end
      if (accept && emit) begin
        out_valid  <= 1'b1;
        out_record <= result;
      end else if (records.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !records.ready) |-> !chars.ready)
    else $error("character taken while a result is stalled");

  a_hunt_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT && accept && c != CHAR_COLON) |=> phase == PH_HUNT)
    else $error("parser left hunting without a colon");

  a_error_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_record.status != ST_DATA) |->
      (out_record.address == 32'd0 && out_record.last == 1'b0 &&
       out_record.data_byte == 8'd0))
    else $error("non-data result carries data fields");

  a_digit_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_count <= 3'd4)
    else $error("digit count out of range");
`endif

endmodule

// File: verif/hrp_record_checker.sv
// Checker that predicts parsed records from character transfers and compares them.
module hrp_record_checker (
  input  logic  clk,
  input  logic  rst,
  hrp_char_if   chars,
  hrp_record_if records,
  input  logic  done,
  output int    pending,
  output int    failures
);
  import hrp_pkg::*;

  typedef enum logic [3:0] {
    P_WAIT, P_HUNT, P_LEN, P_OFFSET, P_TYPE, P_BASE, P_DATA, P_SKIP, P_LF
  } parse_phase_t;

  parse_phase_t phase;
  logic [2:0]   digits;
  logic [7:0]   rec_len;
  logic [15:0]  rec_offset;
  logic [7:0]   rec_type;
  logic [15:0]  upper_base;
  logic [7:0]   byte_acc;
  logic [7:0]   bytes_seen;
  bit           done_seen;
  record_t      expected_records[$];

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    return 4'd0;
  endfunction

  function automatic bit parse_char(input logic [7:0] c, output record_t rec);
    logic [3:0] v;
    bit         hit;
    logic       is_last;
    v = nibble_of(c);
    hit = 1'b0;
    rec = '0;
    // A missing line feed means this character opens the next record.
    if (phase == P_LF) begin
      if (c == CHAR_LF) begin
        phase = P_WAIT;
        return 1'b0;
      end
      phase = P_WAIT;
    end
    case (phase)
      P_WAIT: begin
        if (c == CHAR_COLON) begin
          phase = P_LEN;
          digits = 3'd0;
          rec_len = 8'd0;
        end else begin
          phase = P_HUNT;
          rec.status = ST_BAD_START;
          hit = 1'b1;
        end
      end
      P_HUNT: begin
        if (c == CHAR_COLON) begin
          phase = P_LEN;
          digits = 3'd0;
          rec_len = 8'd0;
        end
      end
      P_LEN: begin
        rec_len = {rec_len[3:0], v};
        digits++;
        if (digits >= 3'd2) begin
          if (rec_len > MAX_LEN || rec_len[0]) begin
            phase = P_HUNT;
            rec.status = ST_BAD_LEN;
            rec.record_length = rec_len;
            hit = 1'b1;
          end else begin
            phase = P_OFFSET;
            digits = 3'd0;
            rec_offset = 16'd0;
          end
        end
      end
      P_OFFSET: begin
        rec_offset = {rec_offset[11:0], v};
        digits++;
        if (digits >= 3'd4) begin
          phase = P_TYPE;
          digits = 3'd0;
          rec_type = 8'd0;
        end
      end
      P_TYPE: begin
        rec_type = {rec_type[3:0], v};
        digits++;
        if (digits >= 3'd2) begin
          digits = 3'd0;
          if (rec_type == REC_EOF) begin
            phase = P_HUNT;
            rec.status = ST_EOF;
            rec.record_length = rec_len;
            hit = 1'b1;
          end else if (rec_type == REC_BASE) begin
            phase = P_BASE;
            upper_base = 16'd0;
          end else if (rec_type == REC_DATA) begin
            bytes_seen = 8'd0;
            byte_acc = 8'd0;
            phase = (rec_len == 8'd0) ? P_SKIP : P_DATA;
          end else begin
            phase = P_HUNT;
            rec.status = ST_BAD_TYPE;
            rec.record_length = rec_len;
            hit = 1'b1;
          end
        end
      end
      P_BASE: begin
        upper_base = {upper_base[11:0], v};
        digits++;
        if (digits >= 3'd4) begin
          phase = P_SKIP;
          digits = 3'd0;
        end
      end
      P_DATA: begin
        byte_acc = {byte_acc[3:0], v};
        digits++;
        if (digits >= 3'd2) begin
          digits = 3'd0;
          is_last = (8'(bytes_seen + 8'd1) == rec_len);
          rec.status = ST_DATA;
          rec.address = {upper_base, rec_offset};
          rec.byte_index = bytes_seen[3:0];
          rec.data_byte = byte_acc;
          rec.record_length = rec_len;
          rec.last = is_last;
          hit = 1'b1;
          bytes_seen = 8'(bytes_seen + 8'd1);
          byte_acc = 8'd0;
          if (is_last) phase = P_SKIP;
        end
      end
      P_SKIP: begin
        digits++;
        if (digits >= 3'd3) begin
          phase = P_LF;
          digits = 3'd0;
        end
      end
      default: phase = P_HUNT;
    endcase
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    failures++;
  endtask

  always @(posedge clk) begin
    record_t got;
    record_t want;
    record_t nxt;
    if (rst) begin
      phase = P_WAIT;
      digits = 3'd0;
      rec_len = 8'd0;
      rec_offset = 16'd0;
      rec_type = 8'd0;
      upper_base = 16'd0;
      byte_acc = 8'd0;
      bytes_seen = 8'd0;
      done_seen = 1'b0;
      failures = 0;
      expected_records.delete();
    end else begin
      if (records.valid && records.ready) begin
        got = records.payload;
        if (expected_records.size() == 0) begin
          report_mismatch($sformatf("unexpected record with status %0d", got.status));
        end else begin
          want = expected_records.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.address !== want.address)
            report_mismatch($sformatf("address %h, expected %h", got.address, want.address));
          if (got.byte_index !== want.byte_index)
            report_mismatch($sformatf("byte_index %0d, expected %0d",
                                      got.byte_index, want.byte_index));
          if (got.data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte %h, expected %h",
                                      got.data_byte, want.data_byte));
          if (got.record_length !== want.record_length)
            report_mismatch($sformatf("record_length %0d, expected %0d",
                                      got.record_length, want.record_length));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
        end
      end
      if (chars.valid && chars.ready) begin
        if (parse_char(chars.character, nxt)) expected_records.push_back(nxt);
      end
      if (done && !done_seen) begin
        done_seen = 1'b1;
        if (expected_records.size() != 0)
          report_mismatch($sformatf("%0d records never arrived", expected_records.size()));
      end
    end
    pending <= expected_records.size();
  end

endmodule

// File: verif/tb.sv
// Top of the hex record parser testbench: clock, reset, character stimulus and verdict.
module tb;
  import hrp_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int ITEM_TARGET = 1450;

  logic clk;
  logic rst;
  logic done;
  int   pending;
  int   failures;
  int   cycles = 0;
  int   items = 0;
  bit   tx_burst;
  bit   rx_burst;
  bit   hold_req;
  logic [7:0] line_q[$];

  hrp_char_if   chars_if();
  hrp_record_if records_if();

  hex_record_parser dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .records (records_if)
  );

  hrp_record_checker record_check (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars_if),
    .records  (records_if),
    .done     (done),
    .pending  (pending),
    .failures (failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + 8'(nib);
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Now and then a digit is replaced by a stray character, which decodes as zero unless it is itself a hex digit.
  task automatic add_field(input logic [15:0] val, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) begin
      if ($urandom_range(0, 49) == 0)
        line_q.push_back($urandom_range(0, 3) == 0 ? CHAR_COLON : 8'($urandom_range(0, 255)));
      else
        line_q.push_back(hex_char(val[i*4 +: 4]));
    end
  endtask

  task automatic build_record();
    int kind;
    int len;
    int rtype;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    line_q.push_back($urandom_range(0, 30) == 0 ? 8'($urandom_range(0, 255)) : CHAR_COLON);
    if (kind < 55) begin
      len = 2 * $urandom_range(0, MAX_LEN / 2);
      add_field(16'(len), 2);
      add_field(pick_value(), 4);
      add_field(16'(REC_DATA), 2);
      repeat (len) add_field(pick_value(), 2);
    end else if (kind < 70) begin
      add_field(16'(2 * $urandom_range(0, MAX_LEN / 2)), 2);
      add_field(pick_value(), 4);
      add_field(16'(REC_BASE), 2);
      add_field(pick_value(), 4);
    end else if (kind < 76) begin
      add_field(16'(2 * $urandom_range(0, 1)), 2);
      add_field(pick_value(), 4);
      add_field(16'(REC_EOF), 2);
    end else if (kind < 82) begin
      do rtype = $urandom_range(0, 255);
      while (rtype == REC_DATA || rtype == REC_EOF || rtype == REC_BASE);
      add_field(16'(2 * $urandom_range(0, MAX_LEN / 2)), 2);
      add_field(pick_value(), 4);
      add_field(16'(rtype), 2);
      add_field(pick_value(), 4);
    end else begin
      do len = $urandom_range(0, 255);
      while (len <= MAX_LEN && len % 2 == 0);
      add_field(16'(len), 2);
      add_field(pick_value(), 4);
      add_field(16'(REC_DATA), 2);
    end
    add_field(pick_value(), 2);
    line_q.push_back($urandom_range(0, 7) == 0 ? 8'($urandom_range(0, 255)) : 8'h0D);
    if ($urandom_range(0, 99) < 85) line_q.push_back(CHAR_LF);
    if ($urandom_range(0, 19) == 0 && line_q.size() > 2)
      line_q = line_q[0 : $urandom_range(1, line_q.size() - 2)];
    items += line_q.size();
  endtask

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.character <= c;
    do @(posedge clk); while (!chars_if.ready);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    line_q.delete();
  endtask

  task automatic wait_drained();
    chars_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int stall;
    records_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        records_if.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 16);
        if (stall > 0) begin
          records_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      records_if.ready <= 1'b1;
      do @(posedge clk); while (!records_if.valid);
      if ($urandom_range(0, 40) == 0) rx_burst = !rx_burst;
    end
  end

  initial begin
    string directed;
    int n;
    rst = 1'b1;
    done = 1'b0;
    chars_if.valid = 1'b0;
    chars_if.character = 8'h00;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Bad start, end of file, odd length, oversized length and an unknown type.
    directed = "G:00000001:01:12:00000005";
    for (n = 0; n < directed.len(); n++) line_q.push_back(directed[n]);
    send_line();
    wait_drained();

    n = 0;
    while (items < ITEM_TARGET) begin
      build_record();
      tx_burst = ($urandom_range(0, 4) == 0);
      if (n == 12) hold_req = 1'b1;
      if (n % 25 == 24) wait_drained();
      send_line();
      n++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    done <= 1'b1;
    repeat (2) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
